>>> hdl/psh_pkg.sv
// Shared types and constants of the pair-sum hash matcher.
// Depends on nothing; every other file of the block imports it.
package psh_pkg;

    localparam int DATA_W   = 32;
    // Bucket count; a power of two, so the non-negative modulo is the low bits.
    localparam int BUCKETS  = 256;
    localparam int WAYS     = 4;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W   = $clog2(WAYS + 1);

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   comp;
        logic                comp_ok;
        logic                clear;
        logic [BUCKET_W-1:0] comp_bucket;
        logic [BUCKET_W-1:0] value_bucket;
    } psh_item_t;

    typedef enum logic {
        ST_LOOK,
        ST_DECIDE
    } psh_state_t;

endpackage

>>> hdl/pair_sum_hash_matcher_unit.sv
// An accepted item is written into the queue, then popped into the back end
// as its bucket row is read; its result is loaded into the result register
// once out_stall allows, and only then does the back end take a new item.
// Front and back are split by a two-entry queue; the result sits in a register.
// Reset (rst_n low, asynchronous) empties the table and sets target_sum to 0.
// No clearing pass: bucket fill counts carry valid bits cleared at once.
module pair_sum_hash_matcher_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psh_pkg::DATA_W-1:0]  target_sum,
    // input item channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [psh_pkg::DATA_W-1:0]  item_value,
    input  logic                        clear_first,
    // result item channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pair_found,
    output logic [psh_pkg::DATA_W-1:0]  earlier_value,
    output logic [psh_pkg::DATA_W-1:0]  later_value,
    output logic                        bucket_overflow
);
    import psh_pkg::*;

    logic [DATA_W-1:0] target_sum_reg, target_sum_next;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    psh_item_t         push_item;
    psh_item_t         head_item;

    // The register is always writable; writes must arrive only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        target_sum_next = target_sum_reg;
        if (cfg_valid && cfg_ready)
        begin
            target_sum_next = target_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else
        begin
            target_sum_reg <= target_sum_next;
        end
    end

    // Classify each item: complement, its range check, both buckets.
    psh_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .item_value  (item_value),
        .clear_first (clear_first),
        .target_sum  (target_sum_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // Decouple intake from the table work.
    psh_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (head_item)
    );

    // Read the complement's bucket row, compare all ways, insert on a miss if the bucket has room.
    psh_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (head_item),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pair_found      (pair_found),
        .earlier_value   (earlier_value),
        .later_value     (later_value),
        .bucket_overflow (bucket_overflow)
    );

endmodule

>>> hdl/psh_front.sv
// Front end of the pair-sum hash matcher: takes items, forms the complement
// and both bucket indexes. Depends on psh_pkg.
module psh_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [psh_pkg::DATA_W-1:0]  item_value,
    input  logic                        clear_first,
    input  logic [psh_pkg::DATA_W-1:0]  target_sum,
    input  logic                        q_full,
    output logic                        q_push,
    output psh_pkg::psh_item_t          q_item
);
    import psh_pkg::*;

    logic signed [DATA_W:0] diff;

    // Exact complement in one extra bit; in range when the top two bits agree.
    assign diff = $signed({target_sum[DATA_W-1], target_sum})
                - $signed({item_value[DATA_W-1], item_value});

    always_comb
    begin
        q_item.value        = item_value;
        q_item.comp         = diff[DATA_W-1:0];
        q_item.comp_ok      = (diff[DATA_W] == diff[DATA_W-1]);
        q_item.clear        = clear_first;
        q_item.comp_bucket  = diff[BUCKET_W-1:0];
        q_item.value_bucket = item_value[BUCKET_W-1:0];
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

>>> hdl/psh_fifo.sv
// Two-entry queue between front and back of the pair-sum hash matcher.
// Depends on psh_pkg for the item type.
module psh_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psh_pkg::psh_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output psh_pkg::psh_item_t  q_item
);
    import psh_pkg::*;

    psh_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/psh_back.sv
// Back end of the pair-sum hash matcher: bucket memories, compare, insert
// and the result register. Depends on psh_pkg.
module psh_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  psh_pkg::psh_item_t          q_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pair_found,
    output logic [psh_pkg::DATA_W-1:0]  earlier_value,
    output logic [psh_pkg::DATA_W-1:0]  later_value,
    output logic                        bucket_overflow
);
    import psh_pkg::*;

    psh_state_t          state_reg, state_next;
    psh_item_t           item_reg;
    logic [BUCKETS-1:0]  valid_reg, valid_next;
    logic [FILL_W-1:0]   fill_mem [BUCKETS];
    logic [FILL_W-1:0]   fill_c_reg, fill_v_reg;
    logic [DATA_W-1:0]   way_rd_reg [WAYS];

    logic                out_valid_reg, out_valid_next;
    logic                pair_found_reg;
    logic [DATA_W-1:0]   earlier_value_reg;
    logic [DATA_W-1:0]   later_value_reg;
    logic                bucket_overflow_reg;

    logic                out_free;
    logic                decide_fire;
    logic [FILL_W-1:0]   fill_c, fill_v;
    logic                hit, ovf, wr_en;
    logic [WAY_W-1:0]    wr_way;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOOK:
            begin
                if (q_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOOK;
                end
            end
            default: state_next = ST_LOOK;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop         = 1'b0;
        decide_fire = 1'b0;
        unique case (state_reg)
            ST_LOOK:   pop         = q_valid;
            ST_DECIDE: decide_fire = out_free;
            default:
            begin
                pop         = 1'b0;
                decide_fire = 1'b0;
            end
        endcase
    end

    // Counts of buckets that are not valid read as zero.
    assign fill_c = valid_reg[item_reg.comp_bucket]  ? fill_c_reg : '0;
    assign fill_v = valid_reg[item_reg.value_bucket] ? fill_v_reg : '0;

    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (item_reg.comp_ok && (FILL_W'(w) < fill_c)
                && (way_rd_reg[w] == item_reg.comp))
            begin
                hit = 1'b1;
            end
        end
        ovf    = !hit && (fill_v >= FILL_W'(WAYS));
        wr_en  = decide_fire && !hit && !ovf;
        wr_way = fill_v[WAY_W-1:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop && q_item.clear)
        begin
            valid_next = '0;
        end
        if (wr_en)
        begin
            valid_next[item_reg.value_bucket] = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (decide_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOOK;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item and load the result register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
        end
        if (decide_fire)
        begin
            pair_found_reg      <= hit;
            earlier_value_reg   <= hit ? item_reg.comp : '0;
            later_value_reg     <= item_reg.value;
            bucket_overflow_reg <= ovf;
        end
    end

    // Fill counts: read at both buckets, write back on insert.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fill_c_reg <= fill_mem[q_item.comp_bucket];
            fill_v_reg <= fill_mem[q_item.value_bucket];
        end
        if (wr_en)
        begin
            fill_mem[item_reg.value_bucket] <= fill_v + FILL_W'(1);
        end
    end

    // One memory per way, so a whole bucket row is read at once.
    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        logic [DATA_W-1:0] way_mem [BUCKETS];

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                way_rd_reg[g] <= way_mem[q_item.comp_bucket];
            end
            if (wr_en && (wr_way == WAY_W'(g)))
            begin
                way_mem[item_reg.value_bucket] <= item_reg.value;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign pair_found      = pair_found_reg;
    assign earlier_value   = earlier_value_reg;
    assign later_value     = later_value_reg;
    assign bucket_overflow = bucket_overflow_reg;

`ifndef NO_ASSERTIONS
    a_pop_leads_decide: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_DECIDE))
        else $error("popped item did not reach the decide step");

    a_insert_fits: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (fill_v < FILL_W'(WAYS)))
        else $error("insert into a full bucket");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        decide_fire |=> !(pair_found && bucket_overflow))
        else $error("pair and overflow flagged together");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> !pop)
        else $error("item taken while another is in flight");
`endif

endmodule
